@@ rtl/bql_pkg.sv @@
package bql_pkg;

  // default sizes, handed to the top level parameters
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int STATE_WIDTH_DEF    = 32;

  // fraction bits of the delay words
  localparam int STATE_FRAC = 8;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_BYPASS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2 = 2'd3;

  // microprogram step addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] STEP_MUL_A1 = 3'd0;
  localparam logic [PC_W-1:0] STEP_MUL_A2 = 3'd1;
  localparam logic [PC_W-1:0] STEP_SUB_A2 = 3'd2;
  localparam logic [PC_W-1:0] STEP_W0     = 3'd3;
  localparam logic [PC_W-1:0] STEP_SUM    = 3'd4;
  localparam logic [PC_W-1:0] STEP_MUL_B0 = 3'd5;
  localparam logic [PC_W-1:0] STEP_LOAD_Y = 3'd6;
  localparam logic [PC_W-1:0] STEP_OUT    = 3'd7;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_A1W1,
    MUL_A2W2,
    MUL_B0SUM
  } mul_sel_e;

  // accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB_P,
    ACC_LOAD_P
  } acc_op_e;

  // branch conditions
  typedef enum logic [0:0] {
    JMP_NONE,
    JMP_BYPASS
  } jmp_e;

  // one control word of the microprogram
  typedef struct packed {
    mul_sel_e        mul_sel;
    acc_op_e         acc_op;
    logic            w0_en;
    logic            sum_en;
    logic            out_en;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            done;
  } uc_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic     take;
    uc_word_t word;
  } bql_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic bypass;
    logic out_stall;
  } bql_status_t;

  localparam uc_word_t UC_NOP = '{
    mul_sel: MUL_NONE,
    acc_op:  ACC_HOLD,
    w0_en:   1'b0,
    sum_en:  1'b0,
    out_en:  1'b0,
    jmp:     JMP_NONE,
    target:  STEP_MUL_A1,
    done:    1'b0
  };

  // microprogram rom
  function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
    uc_word_t w;
    w = UC_NOP;
    unique case (pc)
      STEP_MUL_A1: begin
        w.mul_sel = MUL_A1W1;
        w.acc_op  = ACC_LOAD_X;
        w.jmp     = JMP_BYPASS;
        w.target  = STEP_OUT;
      end
      STEP_MUL_A2: begin
        w.mul_sel = MUL_A2W2;
        w.acc_op  = ACC_SUB_P;
      end
      STEP_SUB_A2: begin
        w.acc_op = ACC_SUB_P;
      end
      STEP_W0: begin
        w.w0_en = 1'b1;
      end
      STEP_SUM: begin
        w.sum_en = 1'b1;
      end
      STEP_MUL_B0: begin
        w.mul_sel = MUL_B0SUM;
      end
      STEP_LOAD_Y: begin
        w.acc_op = ACC_LOAD_P;
      end
      STEP_OUT: begin
        w.out_en = 1'b1;
        w.done   = 1'b1;
      end
      default: begin
        w = UC_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/bql_sequencer.sv @@
module bql_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bql_pkg::bql_status_t   status_i,
  output bql_pkg::bql_ctrl_t     ctrl_o
);

  logic                      busy_q, busy_d;
  logic [bql_pkg::PC_W-1:0]  pc_q, pc_d;
  bql_pkg::uc_word_t         word;
  logic                      stall;
  logic                      take;

  // fetch the current control word
  assign word  = bql_pkg::uc_rom(pc_q);
  assign stall = word.out_en & status_i.out_stall;
  assign take  = in_valid_i & ~busy_q;

  assign in_ready_o  = ~busy_q;
  assign ctrl_o.take = take;
  assign ctrl_o.word = (busy_q && !stall) ? word : bql_pkg::UC_NOP;

  // step counter with conditional branch
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (take) begin
        busy_d = 1'b1;
        pc_d   = bql_pkg::STEP_MUL_A1;
      end
    end else if (!stall) begin
      if (word.done) begin
        busy_d = 1'b0;
      end else if (word.jmp == bql_pkg::JMP_BYPASS && status_i.bypass) begin
        pc_d = word.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= bql_pkg::STEP_MUL_A1;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

@@ rtl/bql_datapath.sv @@
module bql_datapath #(
  parameter int SAMPLE_WIDTH   = bql_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bql_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = bql_pkg::STATE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bql_pkg::bql_ctrl_t              ctrl_i,
  output bql_pkg::bql_status_t            status_o,
  input  logic [SAMPLE_WIDTH-1:0]         sample_i,
  input  logic                            cfg_we_i,
  input  logic [bql_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [COEF_FRAC_BITS+1:0]       cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]         filtered_o,
  output logic                            guard_hit_o
);

  localparam int CW     = COEF_FRAC_BITS + 2;
  localparam int OPB_W  = STATE_WIDTH + 2;
  localparam int PROD_W = CW + OPB_W;
  localparam int XS_W   = SAMPLE_WIDTH + bql_pkg::STATE_FRAC;
  localparam int ACC_W  = (PROD_W + 2 > XS_W + COEF_FRAC_BITS + 2) ?
                          PROD_W + 2 : XS_W + COEF_FRAC_BITS + 2;
  localparam int Y_SHIFT = COEF_FRAC_BITS + bql_pkg::STATE_FRAC;

  // configuration registers
  logic                          bypass_q;
  logic signed [CW-1:0]          b0_q, a1_q, a2_q;

  // delay line
  logic signed [STATE_WIDTH-1:0] w1_q, w2_q;

  // working registers
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [STATE_WIDTH-1:0]  w0_q;
  logic                           guard_q;
  logic signed [OPB_W-1:0]        sum_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q, acc_d;

  // output register
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;
  logic                    out_guard_q;

  logic signed [CW-1:0]     mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]  x_ext, x_acc, x_state;
  logic signed [ACC_W-1:0]  w0_full, y_full;
  logic [ACC_W-STATE_WIDTH:0]  w0_hi;
  logic [ACC_W-SAMPLE_WIDTH:0] y_hi;
  logic                     w0_fits;
  logic [SAMPLE_WIDTH-1:0]  y_sat;

  assign status_o.bypass    = bypass_q;
  assign status_o.out_stall = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_data_q;
  assign guard_hit_o = out_guard_q;

  // sample capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      x_q <= sample_i;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      b0_q     <= '0;
      a1_q     <= '0;
      a2_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bql_pkg::REG_BYPASS:  bypass_q <= cfg_data_i[0];
        bql_pkg::REG_COEF_B0: b0_q     <= cfg_data_i;
        bql_pkg::REG_COEF_A1: a1_q     <= cfg_data_i;
        bql_pkg::REG_COEF_A2: a2_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (ctrl_i.word.mul_sel)
      bql_pkg::MUL_A1W1: begin
        mul_a = a1_q;
        mul_b = OPB_W'(w1_q);
      end
      bql_pkg::MUL_A2W2: begin
        mul_a = a2_q;
        mul_b = OPB_W'(w2_q);
      end
      bql_pkg::MUL_B0SUM: begin
        mul_a = b0_q;
        mul_b = sum_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.word.mul_sel != bql_pkg::MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // accumulator
  assign x_ext   = ACC_W'(x_q);
  assign x_acc   = x_ext <<< Y_SHIFT;
  assign x_state = x_ext <<< bql_pkg::STATE_FRAC;

  always_comb begin
    case (ctrl_i.word.acc_op)
      bql_pkg::ACC_LOAD_X: acc_d = x_acc;
      bql_pkg::ACC_SUB_P:  acc_d = acc_q - ACC_W'(prod_q);
      bql_pkg::ACC_LOAD_P: acc_d = ACC_W'(prod_q);
      default:             acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // round w0 and check the state range
  assign w0_full = (acc_q + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  assign w0_hi   = w0_full[ACC_W-1:STATE_WIDTH-1];
  assign w0_fits = (&w0_hi) | ~(|w0_hi);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.word.w0_en) begin
      w0_q    <= w0_fits ? w0_full[STATE_WIDTH-1:0] : x_state[STATE_WIDTH-1:0];
      guard_q <= ~w0_fits;
    end
    if (ctrl_i.word.sum_en) begin
      sum_q <= OPB_W'(w0_q) + (OPB_W'(w1_q) <<< 1) + OPB_W'(w2_q);
    end
  end

  // round y to an integer and saturate
  assign y_full = (acc_q + (ACC_W'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT;
  assign y_hi   = y_full[ACC_W-1:SAMPLE_WIDTH-1];

  always_comb begin
    if ((&y_hi) | ~(|y_hi)) begin
      y_sat = y_full[SAMPLE_WIDTH-1:0];
    end else if (y_full[ACC_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    end
  end

  // delay line shift and clear on coefficient writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= '0;
      w2_q <= '0;
    end else if (cfg_we_i && cfg_addr_i != bql_pkg::REG_BYPASS) begin
      w1_q <= '0;
      w2_q <= '0;
    end else if (ctrl_i.word.out_en && !bypass_q) begin
      w2_q <= w1_q;
      w1_q <= w0_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.word.out_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.word.out_en) begin
      out_data_q  <= bypass_q ? x_q : y_sat;
      out_guard_q <= bypass_q ? 1'b0 : guard_q;
    end
  end

endmodule

@@ rtl/biquad_lowpass_2nd_order.sv @@
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+--------------------------------
// s_axis    | in        | s_axis_tvalid/tready       | tdata: sample
// m_axis    | out       | m_axis_tvalid/tready       | tdata: filtered, tuser: guard_hit
// cfg       | in        | cfg_valid_i/cfg_ready_o    | cfg_addr_i index, cfg_data_i
//
// a filtered sample runs through all eight steps of the microprogram around the one shared
// multiplier, a bypassed one only through the first and the output step; a new sample is
// taken only once the program is done, so the block does not take one while another is in work.
// a full output register that is not taken holds the program at its output step.
// reset leaves bypass on, coefficients and delay words at zero; cfg is always ready.
module biquad_lowpass_2nd_order #(
  parameter int SAMPLE_WIDTH   = bql_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bql_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = bql_pkg::STATE_WIDTH_DEF,
  localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [TDATA_W-1:0]             s_axis_tdata,   // sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [TDATA_W-1:0]             m_axis_tdata,   // filtered
  output logic [0:0]                     m_axis_tuser,   // guard_hit
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bql_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COEF_FRAC_BITS+1:0]      cfg_data_i
);

  bql_pkg::bql_ctrl_t      ctrl;
  bql_pkg::bql_status_t    status;
  logic [SAMPLE_WIDTH-1:0] filtered;
  logic                    guard_hit;

  assign cfg_ready_o = 1'b1;

  // step sequencer
  bql_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // arithmetic, coefficients and delay line
  bql_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .filtered_o  (filtered),
    .guard_hit_o (guard_hit)
  );

  // pack the result
  assign m_axis_tdata = TDATA_W'(filtered);
  assign m_axis_tuser = guard_hit;

endmodule

@@ rtl/bql_checker.sv @@
module bql_checker #(
  parameter int SAMPLE_WIDTH = bql_pkg::SAMPLE_WIDTH_DEF,
  localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]         m_axis_tuser
);

  logic [2:0] pending_q, pending_d;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // samples taken but not yet delivered
  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // no result without a sample behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 3'd0)
    else $error("result offered with no sample outstanding");

  // a new sample is taken only with nothing in flight but the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> pending_q <= 3'd1)
    else $error("input ready while a sample is still in work");

  // at most one sample in work and one in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("too many samples outstanding");

endmodule

bind biquad_lowpass_2nd_order bql_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bql_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ test/tb_biquad_lowpass_2nd_order.sv @@
`timescale 1ns / 1ps

module tb_biquad_lowpass_2nd_order;
  import bql_pkg::*;

  localparam int SAMPLE_W    = SAMPLE_WIDTH_DEF;
  localparam int COEF_FRAC   = COEF_FRAC_BITS_DEF;
  localparam int STATE_W     = STATE_WIDTH_DEF;
  localparam int COEF_W      = COEF_FRAC + 2;
  localparam int TDATA_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_ITEMS = 55;

  localparam logic [COEF_W-1:0]   COEF_TOP      = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]   COEF_BOTTOM   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       guard_hit;
  } filter_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;   // sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;   // filtered
  logic [0:0]            m_axis_tuser;   // guard_hit
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [COEF_W-1:0]     cfg_data_i;

  // filter state as the block should hold it
  logic   cfg_bypass;
  longint coef_b0;
  longint coef_a1;
  longint coef_a2;
  longint delay_w1;
  longint delay_w2;

  filter_out_t filtered_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int drift_level;
  int stall_count;
  int errors;
  int samples_sent;
  int results_checked;
  int guard_count;
  int reg_writes;

  biquad_lowpass_2nd_order dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // round half up: add half an lsb, then floor shift
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // one filter step on the local state, returns the expected output
  function automatic filter_out_t filter_step(input logic [SAMPLE_W-1:0] sample);
    longint x_scaled;
    longint acc;
    longint w0;
    longint y;
    longint state_max;
    longint sample_max;
    filter_out_t r;
    x_scaled   = longint'($signed(sample)) * (longint'(1) <<< STATE_FRAC);
    state_max  = (longint'(1) <<< (STATE_W - 1)) - 1;
    sample_max = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    r.guard_hit = 1'b0;
    if (cfg_bypass) begin
      r.filtered = sample;
      return r;
    end
    acc = x_scaled * (longint'(1) <<< COEF_FRAC) - coef_a1 * delay_w1 - coef_a2 * delay_w2;
    w0  = round_half_up(acc, COEF_FRAC);
    // state overflow: fall back to the input
    if (w0 > state_max || w0 < -state_max - 1) begin
      w0 = x_scaled;
      r.guard_hit = 1'b1;
    end
    acc = coef_b0 * (w0 + 2 * delay_w1 + delay_w2);
    y   = round_half_up(acc, COEF_FRAC + STATE_FRAC);
    if (y > sample_max) y = sample_max;
    if (y < -sample_max - 1) y = -sample_max - 1;
    delay_w2 = delay_w1;
    delay_w1 = w0;
    r.filtered = y[SAMPLE_W-1:0];
    return r;
  endfunction

  // one sample transaction, with random idle cycles before it
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(sample);
    do @(posedge clk_i); while (!s_axis_tready);
    filtered_q.push_back(filter_step(sample));
    samples_sent++;
  endtask

  // stop offering and wait until every expected result is in
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
  endtask

  // register write transaction, mirrored into the local state
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BYPASS: begin
        cfg_bypass = value[0];
      end
      REG_COEF_B0: begin
        coef_b0  = longint'($signed(value));
        delay_w1 = 0;
        delay_w2 = 0;
      end
      REG_COEF_A1: begin
        coef_a1  = longint'($signed(value));
        delay_w1 = 0;
        delay_w2 = 0;
      end
      REG_COEF_A2: begin
        coef_a2  = longint'($signed(value));
        delay_w1 = 0;
        delay_w2 = 0;
      end
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] a1,
                           input logic [COEF_W-1:0] a2);
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
  endtask

  // a lowpass-like stable set most of the time, otherwise raw or extreme values
  task automatic random_config(input logic bypass_on);
    int mode;
    int a1v;
    int a2v;
    int b0v;
    logic [COEF_W-1:0] bypass_bits;
    logic [COEF_W-1:0] corner[4];
    corner[0] = COEF_TOP;
    corner[1] = COEF_BOTTOM;
    corner[2] = '0;
    corner[3] = COEF_W'($urandom_range(0, 255));
    mode = $urandom_range(5);
    bypass_bits    = COEF_W'($urandom);
    bypass_bits[0] = bypass_on;
    write_reg(REG_BYPASS, bypass_bits);
    if (mode <= 3) begin
      a2v = $urandom_range(0, 58000);
      a1v = -int'($urandom_range(0, 65536 + a2v - 2000));
      b0v = (65536 + a1v + a2v) / 4;
      set_coefs(COEF_W'(b0v), COEF_W'(a1v), COEF_W'(a2v));
    end else if (mode == 4) begin
      set_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
    end else begin
      set_coefs(corner[$urandom_range(3)], corner[$urandom_range(3)],
                corner[$urandom_range(3)]);
    end
  endtask

  // slow drift with noise, full-range values and the two extremes
  function automatic logic [SAMPLE_W-1:0] next_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        drift_level += int'($urandom_range(0, 2000)) - 1000;
        if (drift_level > 32767) drift_level = 32767;
        if (drift_level < -32768) drift_level = -32768;
        return SAMPLE_W'(drift_level);
      end
      4, 5, 6: return SAMPLE_W'($urandom);
      7:       return $urandom_range(1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
      default: return SAMPLE_W'(drift_level + int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // reset state passes samples straight through
  task automatic test_bypass_after_reset();
    send_sample(SAMPLE_TOP);
    send_sample(SAMPLE_BOTTOM);
    send_sample('0);
    send_sample('1);
    send_sample(SAMPLE_W'(1));
    wait_for_results();
  endtask

  // maximum gain drives the output into both rails
  task automatic test_saturation();
    write_reg(REG_BYPASS, '0);
    set_coefs(COEF_TOP, '0, '0);
    send_sample(SAMPLE_TOP);
    send_sample(SAMPLE_BOTTOM);
    send_sample('0);
    send_sample(SAMPLE_W'(1));
    send_sample('1);
    wait_for_results();
  endtask

  // most negative feedback makes the state run away in both directions
  task automatic test_state_overflow();
    set_coefs(COEF_W'(1), COEF_BOTTOM, COEF_BOTTOM);
    repeat (6) send_sample(SAMPLE_TOP);
    repeat (4) send_sample(SAMPLE_BOTTOM);
    wait_for_results();
  endtask

  // bypass must leave the delay words alone; upper data bits are don't-care
  task automatic test_bypass_keeps_state();
    write_reg(REG_BYPASS, {COEF_W{1'b1}});
    send_sample(SAMPLE_W'(12345));
    send_sample(SAMPLE_BOTTOM);
    wait_for_results();
    write_reg(REG_BYPASS, {{(COEF_W-1){1'b1}}, 1'b0});
    send_sample(SAMPLE_W'(-200));
    send_sample(SAMPLE_W'(77));
    wait_for_results();
  endtask

  // long receiver stall fills the block, then a full drain before carrying on
  task automatic test_backpressure();
    int saved_send;
    int saved_recv;
    saved_send    = send_idle_pct;
    saved_recv    = recv_idle_pct;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_config(1'b0);
    @(negedge clk_i);
    hold_cycles = HOLD_CYCLES;
    repeat (20) send_sample(next_sample());
    wait_for_results();
    repeat (10) send_sample(next_sample());
    wait_for_results();
    send_idle_pct = saved_send;
    recv_idle_pct = saved_recv;
  endtask

  // random configurations and samples under each idling pattern
  task automatic test_random_filtering();
    int mode;
    int ph;
    int n;
    logic bypass_on;
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 56 : 0;
      recv_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 24 : 0;
      for (ph = 0; ph < 4; ph++) begin
        wait_for_results();
        bypass_on = ($urandom_range(7) == 0);
        random_config(bypass_on);
        for (n = 0; n < PHASE_ITEMS; n++) begin
          // occasional bypass stretch in the middle of a filtering run
          if (n == PHASE_ITEMS / 2 && !bypass_on && $urandom_range(2) == 0) begin
            wait_for_results();
            write_reg(REG_BYPASS, COEF_W'({$urandom, 1'b1}));
            repeat (5) send_sample(next_sample());
            wait_for_results();
            write_reg(REG_BYPASS, COEF_W'({$urandom, 1'b0}));
          end
          send_sample(next_sample());
        end
      end
    end
    wait_for_results();
  endtask

  // receiver side: random ready, or a counted hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    filter_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected result: filtered %0d guard_hit %0d",
               $signed(m_axis_tdata[SAMPLE_W-1:0]), m_axis_tuser[0]);
        errors++;
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata[SAMPLE_W-1:0] !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered,
                 $signed(m_axis_tdata[SAMPLE_W-1:0]));
          errors++;
        end
        if (m_axis_tuser[0] !== want.guard_hit) begin
          $error("guard_hit: expected %0d, got %0d", want.guard_hit, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[0]) guard_count++;
        results_checked++;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
        $display("biquad_lowpass_2nd_order verification failed");
        $finish;
      end
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = REG_BYPASS;
    cfg_data_i      = '0;
    cfg_bypass      = 1'b1;
    coef_b0         = 0;
    coef_a1         = 0;
    coef_a2         = 0;
    delay_w1        = 0;
    delay_w2        = 0;
    send_idle_pct   = 24;
    recv_idle_pct   = 56;
    hold_cycles     = 0;
    drift_level     = 0;
    stall_count     = 0;
    errors          = 0;
    samples_sent    = 0;
    results_checked = 0;
    guard_count     = 0;
    reg_writes      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_bypass_after_reset();
    test_saturation();
    test_state_overflow();
    test_bypass_keeps_state();
    test_backpressure();
    test_random_filtering();

    wait_for_results();
    repeat (20) @(posedge clk_i);
    $display("covered %0d samples and %0d register writes over bypass, saturation,",
             samples_sent, reg_writes);
    $display("state overflow (%0d guard hits) and stall patterns; %0d results checked",
             guard_count, results_checked);
    if (errors == 0) begin
      $display("biquad_lowpass_2nd_order verification clean");
    end else begin
      $display("biquad_lowpass_2nd_order verification failed");
    end
    $finish;
  end

endmodule
